@@ rtl/clbs_pkg.sv @@
// clbs_pkg: types, codes, constants and lookup functions for the character LCD bus sequencer.
// No dependencies; every other file of the block uses it.
package clbs_pkg;

    localparam int MAX_DIGITS_DEF  = 10;
    localparam int MAX_COLUMNS_DEF = 20;

    localparam int CMD_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int NIB_W       = 4;
    localparam int SETTLE_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int INIT_STEP_W = 4;
    localparam int BIT_CNT_W   = 6;

    localparam logic [INIT_STEP_W-1:0] INIT_LAST_STEP = 4'd8;
    localparam logic [BIT_CNT_W-1:0]   CONV_STEPS     = BIT_CNT_W'(VALUE_W);

    localparam logic [BYTE_W-1:0] CURSOR_OPCODE = 8'd128;
    localparam logic [BYTE_W-1:0] ASCII_ZERO    = 8'd48;
    localparam logic [ROW_W-1:0]  ROW_FIRST     = 3'd1;
    localparam logic [ROW_W-1:0]  ROW_LAST      = 3'd4;

    localparam logic [SETTLE_W-1:0] SETTLE_NONE  = 2'd0;
    localparam logic [SETTLE_W-1:0] SETTLE_SHORT = 2'd1;
    localparam logic [SETTLE_W-1:0] SETTLE_LONG  = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_POS = 1'b1;
    localparam logic RS_INSTR       = 1'b0;
    localparam logic RS_DATA        = 1'b1;

    localparam logic                 CFG_BUS_EIGHT_RST = 1'b0;
    localparam logic [NIB_W-1:0]     CFG_FSET_NIB_RST  = 4'd8;
    localparam logic [BYTE_W-1:0]    CFG_DISP_CTRL_RST = 8'd12;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSTR  = 3'd0,
        CMD_DATA   = 3'd1,
        CMD_CURSOR = 3'd2,
        CMD_CHAR   = 3'd3,
        CMD_INT    = 3'd4,
        CMD_INIT   = 3'd5
    } cmd_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUS_EIGHT = 2'd0,
        CFG_FSET_NIB  = 2'd1,
        CFG_DISP_CTRL = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SRC_VALUE,
        SRC_CURSOR,
        SRC_DIGIT
    } src_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_ERROR,
        EMIT_FULL,
        EMIT_HIGH,
        EMIT_LOW,
        EMIT_INIT
    } emit_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ERROR,
        ST_BYTE_HI,
        ST_BYTE_LO,
        ST_CONVERT,
        ST_SCAN,
        ST_INIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic  load;
        logic  conv_step;
        logic  dig_dec;
        emit_t emit;
        src_t  src;
        logic  last;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             pos_ok;
        logic             eight_bit;
        logic             conv_done;
        logic             digit_zero;
        logic             dig_idx_zero;
        logic             init_last;
        logic             out_free;
    } dp_status_t;

    typedef struct packed {
        logic [SETTLE_W-1:0] settle;
        logic [NIB_W-1:0]    nib;
    } init_entry_t;

    function automatic logic [BYTE_W-1:0] row_base(input logic [ROW_W-1:0] row);
        logic [BYTE_W-1:0] base;
        unique case (row)
            3'd2:    base = 8'h40;
            3'd3:    base = 8'h14;
            3'd4:    base = 8'h54;
            default: base = 8'h00;
        endcase
        return base;
    endfunction

    // 4-bit power-up nibble sequence
    function automatic init_entry_t init_entry(input logic [INIT_STEP_W-1:0] step,
                                               input logic [NIB_W-1:0] fset_nib,
                                               input logic [BYTE_W-1:0] disp_ctrl);
        init_entry_t e;
        unique case (step)
            4'd0:    e = '{settle: SETTLE_SHORT, nib: 4'h2};
            4'd1:    e = '{settle: SETTLE_NONE,  nib: 4'h2};
            4'd2:    e = '{settle: SETTLE_SHORT, nib: fset_nib};
            4'd3:    e = '{settle: SETTLE_NONE,  nib: 4'h0};
            4'd4:    e = '{settle: SETTLE_LONG,  nib: 4'h1};
            4'd5:    e = '{settle: SETTLE_NONE,  nib: 4'h0};
            4'd6:    e = '{settle: SETTLE_SHORT, nib: 4'h2};
            4'd7:    e = '{settle: SETTLE_NONE,  nib: disp_ctrl[7:4]};
            4'd8:    e = '{settle: SETTLE_SHORT, nib: disp_ctrl[3:0]};
            default: e = '{settle: SETTLE_NONE,  nib: 4'h0};
        endcase
        return e;
    endfunction

endpackage

@@ rtl/clbs_req_if.sv @@
// clbs_req_if: command channel (valid/ready plus command payload).
// Depends on clbs_pkg for field widths.
interface clbs_req_if;
    logic                         valid;
    logic                         ready;
    logic [clbs_pkg::CMD_W-1:0]   cmd;
    logic [clbs_pkg::VALUE_W-1:0] value;
    logic [clbs_pkg::ROW_W-1:0]   row;
    logic [clbs_pkg::COL_W-1:0]   column;

    modport source (output valid, output cmd, output value, output row, output column,
                    input ready);
    modport sink   (input valid, input cmd, input value, input row, input column,
                    output ready);
endinterface

@@ rtl/clbs_res_if.sv @@
// clbs_res_if: result channel (valid/ready plus one bus transfer result).
// Depends on clbs_pkg for field widths.
interface clbs_res_if;
    logic                          valid;
    logic                          ready;
    logic                          strobe_res;
    logic                          reg_select;
    logic [clbs_pkg::BYTE_W-1:0]   data_lines;
    logic [clbs_pkg::SETTLE_W-1:0] settle;
    logic                          status;
    logic                          last;

    modport source (output valid, output strobe_res, output reg_select, output data_lines,
                    output settle, output status, output last, input ready);
    modport sink   (input valid, input strobe_res, input reg_select, input data_lines,
                    input settle, input status, input last, output ready);
endinterface

@@ rtl/clbs_dpath.sv @@
// clbs_dpath: config registers, command hold, binary-to-BCD unit, digit pointer,
// power-up step counter and the result output register. Uses clbs_pkg, clbs_res_if.
module clbs_dpath #(
    parameter int MAX_DIGITS  = clbs_pkg::MAX_DIGITS_DEF,
    parameter int MAX_COLUMNS = clbs_pkg::MAX_COLUMNS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [clbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clbs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [clbs_pkg::CMD_W-1:0]        req_cmd,
    input  logic [clbs_pkg::VALUE_W-1:0]      req_value,
    input  logic [clbs_pkg::ROW_W-1:0]        req_row,
    input  logic [clbs_pkg::COL_W-1:0]        req_column,
    input  clbs_pkg::ctrl_cmd_t               ctl,
    output clbs_pkg::dp_status_t              sts,
    clbs_res_if.source                        rsp
);
    import clbs_pkg::*;

    localparam int DIG_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [DIG_W-1:0] DIG_TOP   = DIG_W'(MAX_DIGITS - 1);
    localparam logic [COL_W+1:0] COL_LIMIT = (COL_W + 2)'(MAX_COLUMNS);

    // configuration
    logic               bus_eight_reg, bus_eight_next;
    logic [NIB_W-1:0]   fset_nib_reg, fset_nib_next;
    logic [BYTE_W-1:0]  disp_ctrl_reg, disp_ctrl_next;

    // command hold
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;

    // binary-to-BCD shift-add unit
    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [NIB_W-1:0]     bcd_reg [MAX_DIGITS];
    logic [NIB_W-1:0]     bcd_next [MAX_DIGITS];
    logic [NIB_W-1:0]     bcd_adj [MAX_DIGITS];
    logic [MAX_DIGITS-1:0] bcd_carry;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DIG_W-1:0]     dig_idx_reg, dig_idx_next;
    logic [INIT_STEP_W-1:0] init_step_reg, init_step_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic                 o_strobe_reg, o_strobe_next;
    logic                 o_rs_reg, o_rs_next;
    logic [BYTE_W-1:0]    o_data_reg, o_data_next;
    logic [SETTLE_W-1:0]  o_settle_reg, o_settle_next;
    logic                 o_status_reg, o_status_next;
    logic                 o_last_reg, o_last_next;

    logic [BYTE_W-1:0] cursor_addr;
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_rs;
    logic [NIB_W-1:0]  cur_digit;
    logic              row_ok;
    logic              col_ok;
    init_entry_t       init_e;

    assign cursor_addr = CURSOR_OPCODE + row_base(row_reg) + {3'b000, col_reg} - 8'd1;
    assign row_ok      = (row_reg >= ROW_FIRST) && (row_reg <= ROW_LAST);
    assign col_ok      = (col_reg != '0) && ({2'b00, col_reg} <= COL_LIMIT);
    assign cur_digit   = bcd_reg[dig_idx_reg];
    assign init_e      = init_entry(init_step_reg, fset_nib_reg, disp_ctrl_reg);

    always_comb
    begin
        unique case (ctl.src)
            SRC_CURSOR:
            begin
                tx_byte = cursor_addr;
                tx_rs   = RS_INSTR;
            end
            SRC_DIGIT:
            begin
                tx_byte = ASCII_ZERO + {4'h0, cur_digit};
                tx_rs   = RS_DATA;
            end
            default:
            begin
                tx_byte = byte_reg;
                tx_rs   = (cmd_reg == CMD_INSTR) ? RS_INSTR : RS_DATA;
            end
        endcase
    end

    // config writes; an index past the list is dropped
    always_comb
    begin
        bus_eight_next = bus_eight_reg;
        fset_nib_next  = fset_nib_reg;
        disp_ctrl_next = disp_ctrl_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BUS_EIGHT: bus_eight_next = cfg_data[0];
                CFG_FSET_NIB:  fset_nib_next  = cfg_data[NIB_W-1:0];
                CFG_DISP_CTRL: disp_ctrl_next = cfg_data;
                default: ;
            endcase
        end
    end

    // one shift-add-3 step over all digits
    always_comb
    begin
        bcd_carry[0] = bin_reg[VALUE_W-1];
        for (int d = 0; d < MAX_DIGITS; d++)
        begin
            bcd_adj[d] = (bcd_reg[d] >= 4'd5) ? bcd_reg[d] + 4'd3 : bcd_reg[d];
        end
        for (int d = 1; d < MAX_DIGITS; d++)
        begin
            bcd_carry[d] = bcd_adj[d-1][NIB_W-1];
        end
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        byte_next      = byte_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_idx_next   = dig_idx_reg;
        init_step_next = init_step_reg;

        if (ctl.load)
        begin
            cmd_next       = req_cmd;
            byte_next      = req_value[BYTE_W-1:0];
            row_next       = req_row;
            col_next       = req_column;
            bin_next       = req_value;
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                bcd_next[d] = '0;
            end
            bit_cnt_next   = '0;
            dig_idx_next   = DIG_TOP;
            init_step_next = '0;
        end
        else
        begin
            if (ctl.conv_step)
            begin
                bin_next     = {bin_reg[VALUE_W-2:0], 1'b0};
                for (int d = 0; d < MAX_DIGITS; d++)
                begin
                    bcd_next[d] = {bcd_adj[d][NIB_W-2:0], bcd_carry[d]};
                end
                bit_cnt_next = bit_cnt_reg + 1'b1;
            end
            if (ctl.dig_dec)
            begin
                dig_idx_next = dig_idx_reg - 1'b1;
            end
            if (ctl.emit == EMIT_INIT)
            begin
                init_step_next = init_step_reg + 1'b1;
            end
        end
    end

    // result register: a new beat may be loaded in the cycle the old one leaves
    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        o_strobe_next  = o_strobe_reg;
        o_rs_next      = o_rs_reg;
        o_data_next    = o_data_reg;
        o_settle_next  = o_settle_reg;
        o_status_next  = o_status_reg;
        o_last_next    = o_last_reg;
        if (ctl.emit != EMIT_NONE)
        begin
            out_valid_next = 1'b1;
            o_strobe_next  = 1'b1;
            o_rs_next      = tx_rs;
            o_settle_next  = SETTLE_NONE;
            o_status_next  = STATUS_OK;
            o_last_next    = ctl.last;
            o_data_next    = tx_byte;
            unique case (ctl.emit)
                EMIT_ERROR:
                begin
                    o_strobe_next = 1'b0;
                    o_rs_next     = RS_INSTR;
                    o_data_next   = '0;
                    o_status_next = STATUS_BAD_POS;
                end
                EMIT_HIGH: o_data_next = {4'h0, tx_byte[BYTE_W-1:NIB_W]};
                EMIT_LOW:  o_data_next = {4'h0, tx_byte[NIB_W-1:0]};
                EMIT_INIT:
                begin
                    o_rs_next     = RS_INSTR;
                    o_data_next   = {4'h0, init_e.nib};
                    o_settle_next = init_e.settle;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_eight_reg <= CFG_BUS_EIGHT_RST;
            fset_nib_reg  <= CFG_FSET_NIB_RST;
            disp_ctrl_reg <= CFG_DISP_CTRL_RST;
            bit_cnt_reg   <= '0;
            dig_idx_reg   <= '0;
            init_step_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bus_eight_reg <= bus_eight_next;
            fset_nib_reg  <= fset_nib_next;
            disp_ctrl_reg <= disp_ctrl_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_idx_reg   <= dig_idx_next;
            init_step_reg <= init_step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        byte_reg     <= byte_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        o_strobe_reg <= o_strobe_next;
        o_rs_reg     <= o_rs_next;
        o_data_reg   <= o_data_next;
        o_settle_reg <= o_settle_next;
        o_status_reg <= o_status_next;
        o_last_reg   <= o_last_next;
    end

    assign sts.cmd          = cmd_reg;
    assign sts.pos_ok       = row_ok && col_ok;
    assign sts.eight_bit    = bus_eight_reg;
    assign sts.conv_done    = (bit_cnt_reg == CONV_STEPS);
    assign sts.digit_zero   = (cur_digit == '0);
    assign sts.dig_idx_zero = (dig_idx_reg == '0);
    assign sts.init_last    = (init_step_reg == INIT_LAST_STEP);
    assign sts.out_free     = !out_valid_reg || rsp.ready;

    assign rsp.valid      = out_valid_reg;
    assign rsp.strobe_res = o_strobe_reg;
    assign rsp.reg_select = o_rs_reg;
    assign rsp.data_lines = o_data_reg;
    assign rsp.settle     = o_settle_reg;
    assign rsp.status     = o_status_reg;
    assign rsp.last       = o_last_reg;

endmodule

@@ rtl/clbs_ctrl.sv @@
// clbs_ctrl: command sequencer state machine; drives the datapath by a command struct.
// Uses clbs_pkg (state, command and status types).
module clbs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  clbs_pkg::dp_status_t  sts,
    output clbs_pkg::ctrl_cmd_t   ctl
);
    import clbs_pkg::*;

    state_t state_reg, state_next;
    src_t   src_reg, src_next;
    logic   byte_final;
    logic   byte_done;

    // final beat of the byte being sent also ends the command
    always_comb
    begin
        unique case (src_reg)
            SRC_CURSOR: byte_final = (sts.cmd == CMD_CURSOR);
            SRC_DIGIT:  byte_final = sts.dig_idx_zero;
            default:    byte_final = 1'b1;
        endcase
    end

    assign byte_done = sts.out_free &&
                       (((state_reg == ST_BYTE_HI) && sts.eight_bit) ||
                        (state_reg == ST_BYTE_LO));

    // next state
    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (sts.cmd)
                    CMD_INSTR, CMD_DATA:
                    begin
                        src_next   = SRC_VALUE;
                        state_next = ST_BYTE_HI;
                    end
                    CMD_CURSOR, CMD_CHAR, CMD_INT:
                    begin
                        src_next   = SRC_CURSOR;
                        state_next = sts.pos_ok ? ST_BYTE_HI : ST_ERROR;
                    end
                    CMD_INIT: state_next = ST_INIT;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_ERROR:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BYTE_HI, ST_BYTE_LO:
            begin
                if (byte_done)
                begin
                    unique case (src_reg)
                        SRC_CURSOR:
                        begin
                            if (sts.cmd == CMD_CHAR)
                            begin
                                src_next   = SRC_VALUE;
                                state_next = ST_BYTE_HI;
                            end
                            else if (sts.cmd == CMD_INT)
                            begin
                                state_next = ST_CONVERT;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        SRC_DIGIT:
                            state_next = sts.dig_idx_zero ? ST_IDLE : ST_BYTE_HI;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
                else if ((state_reg == ST_BYTE_HI) && sts.out_free)
                begin
                    state_next = ST_BYTE_LO;
                end
            end
            ST_CONVERT:
            begin
                if (sts.conv_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // skip leading zeros, always keep the ones digit
                if (!sts.digit_zero || sts.dig_idx_zero)
                begin
                    src_next   = SRC_DIGIT;
                    state_next = ST_BYTE_HI;
                end
            end
            ST_INIT:
            begin
                if (sts.out_free && sts.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        ctl.load      = in_valid && (state_reg == ST_IDLE);
        ctl.conv_step = (state_reg == ST_CONVERT) && !sts.conv_done;
        ctl.dig_dec   = 1'b0;
        ctl.emit      = EMIT_NONE;
        ctl.src       = src_reg;
        ctl.last      = 1'b0;
        unique case (state_reg)
            ST_ERROR:
            begin
                if (sts.out_free)
                begin
                    ctl.emit = EMIT_ERROR;
                    ctl.last = 1'b1;
                end
            end
            ST_BYTE_HI:
            begin
                if (sts.out_free)
                begin
                    ctl.emit = sts.eight_bit ? EMIT_FULL : EMIT_HIGH;
                    ctl.last = sts.eight_bit && byte_final;
                end
            end
            ST_BYTE_LO:
            begin
                if (sts.out_free)
                begin
                    ctl.emit = EMIT_LOW;
                    ctl.last = byte_final;
                end
            end
            ST_SCAN:
                ctl.dig_dec = sts.digit_zero && !sts.dig_idx_zero;
            ST_INIT:
            begin
                if (sts.out_free)
                begin
                    ctl.emit = EMIT_INIT;
                    ctl.last = sts.init_last;
                end
            end
            default: ;
        endcase
        if (byte_done && (src_reg == SRC_DIGIT) && !sts.dig_idx_zero)
        begin
            ctl.dig_dec = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            src_reg   <= SRC_VALUE;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
        end
    end

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit != EMIT_NONE) |-> sts.out_free)
        else $error("beat loaded while result register still full");

    a_conv_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.conv_step |-> !sts.conv_done)
        else $error("BCD unit stepped past the value width");

    a_dig_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.dig_dec |-> !sts.dig_idx_zero)
        else $error("digit pointer decremented below zero");

    a_low_nibble_4bit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit == EMIT_LOW) |-> !sts.eight_bit)
        else $error("low nibble beat in 8-bit bus mode");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DISPATCH))
        else $error("accepted command not dispatched");

endmodule

@@ rtl/char_lcd_bus_sequencer_unit.sv @@
// char_lcd_bus_sequencer_unit: top level of the character LCD bus sequencer.
// Depends on clbs_pkg, clbs_req_if, clbs_res_if, clbs_dpath and clbs_ctrl.
//
//   channel  dir   handshake            beat contents
//   req      in    req.valid/req.ready  cmd, value, row, column
//   rsp      out   rsp.valid/rsp.ready  strobe_res, reg_select, data_lines, settle, status, last
//   cfg      in    cfg_we (no ready)    cfg_index, cfg_data
//
// One command at a time: accept, a dispatch state, then one result beat per cycle
// while rsp keeps up. Instruction/data: one byte. Cursor: the cursor byte; char adds
// the character byte. Integer: cursor byte, 32 steps in the shift-add-3 BCD unit and
// the done check, a leading-zero scan, then one beat per digit on the 8-bit bus and
// two on the 4-bit bus. An off-panel position gives one error beat with no strobe.
// Power-up sequence: nine nibble beats. Results sit in one output register, so a stall on rsp
// holds the sequencer only when a second beat is ready; req is taken again once the
// last beat is loaded. Reset clears control and config; no clearing pass.
module char_lcd_bus_sequencer_unit #(
    parameter int MAX_DIGITS  = clbs_pkg::MAX_DIGITS_DEF,
    parameter int MAX_COLUMNS = clbs_pkg::MAX_COLUMNS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [clbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [clbs_pkg::CFG_DATA_W-1:0]  cfg_data,
    clbs_req_if.sink                         req,
    clbs_res_if.source                       rsp
);
    import clbs_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t sts;

    // sequencer: owns req.ready and all step decisions
    clbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // datapath: config, BCD unit, cursor math and the result register
    clbs_dpath #(
        .MAX_DIGITS  (MAX_DIGITS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_cmd    (req.cmd),
        .req_value  (req.value),
        .req_row    (req.row),
        .req_column (req.column),
        .ctl        (ctl),
        .sts        (sts),
        .rsp        (rsp)
    );

endmodule

@@ sim/tb.sv @@
// tb: self-checking bench for char_lcd_bus_sequencer_unit.
// Depends on clbs_pkg, clbs_req_if, clbs_res_if and the RTL of the block.
// A scoreboard class predicts every result beat per command; plain tasks drive the ports.
module tb;
    import clbs_pkg::*;

    // run control
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 80;   // idle wait after the last predicted beat, plus margin
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 36;

    // command codes the block must ignore
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    // one result beat, field order matches the rsp payload
    typedef struct packed {
        logic                strobe;
        logic                rs;
        logic [BYTE_W-1:0]   lines;
        logic [SETTLE_W-1:0] settle;
        logic                status;
        logic                last;
    } lcd_beat_t;

    // Predicts the strobe beats of each accepted command and checks
    // observed beats against them in order.
    class lcd_strobe_board;
        lcd_beat_t         beats_due[$];
        logic              eight_bit;
        logic [NIB_W-1:0]  fset_nib;
        logic [BYTE_W-1:0] disp_ctrl;
        int                errors;
        int                beats_seen;
        int                commands_seen;

        function new();
            eight_bit     = CFG_BUS_EIGHT_RST;
            fset_nib      = CFG_FSET_NIB_RST;
            disp_ctrl     = CFG_DISP_CTRL_RST;
            errors        = 0;
            beats_seen    = 0;
            commands_seen = 0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BUS_EIGHT: eight_bit = data[0];
                CFG_FSET_NIB:  fset_nib  = data[NIB_W-1:0];
                CFG_DISP_CTRL: disp_ctrl = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return beats_due.size();
        endfunction

        function void push_beat(logic strobe, logic rs, logic [BYTE_W-1:0] lines,
                                logic [SETTLE_W-1:0] settle, logic status);
            lcd_beat_t b;
            b = '{strobe: strobe, rs: rs, lines: lines, settle: settle,
                  status: status, last: 1'b0};
            beats_due.push_back(b);
        endfunction

        // power-up nibble, always an instruction strobe on the low lines
        function void push_nibble(logic [NIB_W-1:0] nib, logic [SETTLE_W-1:0] settle);
            push_beat(1'b1, RS_INSTR, {4'h0, nib}, settle, STATUS_OK);
        endfunction

        function void push_byte(logic [BYTE_W-1:0] b, logic rs);
            if (eight_bit)
            begin
                push_beat(1'b1, rs, b, SETTLE_NONE, STATUS_OK);
            end
            else
            begin
                push_beat(1'b1, rs, {4'h0, b[7:4]}, SETTLE_NONE, STATUS_OK);
                push_beat(1'b1, rs, {4'h0, b[3:0]}, SETTLE_NONE, STATUS_OK);
            end
        endfunction

        // 0 when the position is off the panel; nothing is queued then
        function bit push_cursor(logic [ROW_W-1:0] row, logic [COL_W-1:0] column);
            logic [BYTE_W-1:0] base;
            if (column < 1 || column > MAX_COLUMNS_DEF)
                return 1'b0;
            case (row)
                3'd1:    base = 8'h00;
                3'd2:    base = 8'h40;
                3'd3:    base = 8'h14;
                3'd4:    base = 8'h54;
                default: return 1'b0;
            endcase
            push_byte(CURSOR_OPCODE + base + BYTE_W'(column - 1), RS_INSTR);
            return 1'b1;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                                   logic [ROW_W-1:0] row, logic [COL_W-1:0] column);
            int                 start_depth;
            int                 ndig;
            logic [VALUE_W-1:0] rest;
            logic [3:0]         digits[MAX_DIGITS_DEF];
            start_depth = beats_due.size();
            case (cmd)
                CMD_INSTR: push_byte(value[7:0], RS_INSTR);
                CMD_DATA:  push_byte(value[7:0], RS_DATA);
                CMD_CURSOR, CMD_CHAR, CMD_INT:
                begin
                    if (!push_cursor(row, column))
                    begin
                        push_beat(1'b0, RS_INSTR, 8'h00, SETTLE_NONE, STATUS_BAD_POS);
                    end
                    else if (cmd == CMD_CHAR)
                    begin
                        push_byte(value[7:0], RS_DATA);
                    end
                    else if (cmd == CMD_INT)
                    begin
                        // least significant digit first, printed most significant first
                        rest = value;
                        ndig = 0;
                        do
                        begin
                            digits[ndig] = 4'(rest % 10);
                            rest = rest / 10;
                            ndig++;
                        end
                        while (rest != 0 && ndig < MAX_DIGITS_DEF);
                        for (int i = ndig - 1; i >= 0; i--)
                            push_byte(ASCII_ZERO + BYTE_W'(digits[i]), RS_DATA);
                    end
                end
                CMD_INIT:
                begin
                    push_nibble(4'h2, SETTLE_SHORT);
                    push_nibble(4'h2, SETTLE_NONE);
                    push_nibble(fset_nib, SETTLE_SHORT);
                    push_nibble(4'h0, SETTLE_NONE);
                    push_nibble(4'h1, SETTLE_LONG);
                    push_nibble(4'h0, SETTLE_NONE);
                    push_nibble(4'h2, SETTLE_SHORT);
                    push_nibble(disp_ctrl[7:4], SETTLE_NONE);
                    push_nibble(disp_ctrl[3:0], SETTLE_SHORT);
                end
                default: ;
            endcase
            if (beats_due.size() > start_depth)
            begin
                beats_due[beats_due.size() - 1].last = 1'b1;
                commands_seen++;
            end
        endfunction

        function void check_field(string name, logic [BYTE_W-1:0] want,
                                  logic [BYTE_W-1:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_beat(lcd_beat_t got);
            lcd_beat_t want;
            beats_seen++;
            if (beats_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
                return;
            end
            want = beats_due.pop_front();
            check_field("strobe_res", BYTE_W'(want.strobe), BYTE_W'(got.strobe));
            check_field("reg_select", BYTE_W'(want.rs), BYTE_W'(got.rs));
            check_field("data_lines", want.lines, got.lines);
            check_field("settle", BYTE_W'(want.settle), BYTE_W'(got.settle));
            check_field("status", BYTE_W'(want.status), BYTE_W'(got.status));
            check_field("last", BYTE_W'(want.last), BYTE_W'(got.last));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    clbs_req_if req_ch ();
    clbs_res_if rsp_ch ();

    lcd_strobe_board board;
    bit              idling_on;
    int              cycle_count;
    int              rsp_stall_left;
    int              settings_used;
    int              spare_sent;

    char_lcd_bus_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // 20-unit clock period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog: a hung handshake or a lost beat ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("cycle limit hit with %0d beats outstanding", board.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: check each accepted beat against the predicted one, then
    // pick ready for the next cycle. Stalls come in random bursts while idling is on.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_beat({rsp_ch.strobe_res, rsp_ch.reg_select, rsp_ch.data_lines,
                              rsp_ch.settle, rsp_ch.status, rsp_ch.last});
        if (rsp_stall_left > 0)
        begin
            rsp_stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            rsp_stall_left = $urandom_range(0, 8);
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // One command beat. An optional idle burst goes first; valid stays high
    // straight into the next beat when there is none, so it never toggles
    // twice in one step.
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                                logic [ROW_W-1:0] row, logic [COL_W-1:0] column);
        int gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.cmd    <= cmd;
        req_ch.value  <= value;
        req_ch.row    <= row;
        req_ch.column <= column;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_command(cmd, value, row, column);
        if (cmd == CMD_SPARE_A || cmd == CMD_SPARE_B)
            spare_sent++;
    endtask

    // Drop valid, let every predicted beat arrive, then cover the latency of a
    // trailing ignored command before anything touches the registers.
    task automatic drain_block();
        req_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.set_register(idx, data);
    endtask

    // only called with the block idle
    task automatic apply_settings(logic eight, logic [NIB_W-1:0] nib, logic [BYTE_W-1:0] ctrl);
        write_register(CFG_BUS_EIGHT, {7'd0, eight});
        write_register(CFG_FSET_NIB, {4'd0, nib});
        write_register(CFG_DISP_CTRL, ctrl);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Random command mix: mostly valid positions, integers of every length,
    // an occasional power-up and now and then a code the block ignores.
    task automatic random_command(output bit counted);
        int                 pick;
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            cmd = CMD_INSTR;
        else if (pick < 30)
            cmd = CMD_DATA;
        else if (pick < 45)
            cmd = CMD_CURSOR;
        else if (pick < 62)
            cmd = CMD_CHAR;
        else if (pick < 88)
            cmd = CMD_INT;
        else if (pick < 96)
            cmd = CMD_INIT;
        else if (pick < 98)
            cmd = CMD_SPARE_A;
        else
            cmd = CMD_SPARE_B;

        if (cmd == CMD_INT)
        begin
            case ($urandom_range(0, 3))
                0:       value = $urandom_range(0, 9);
                1:       value = $urandom;
                2:       value = $urandom >> $urandom_range(0, 31);
                default: value = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'd1000000000;
            endcase
        end
        else
        begin
            value = $urandom;
        end

        row    = ROW_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
                                                    : $urandom_range(1, 4));
        column = COL_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(1, 20));
        send_command(cmd, value, row, column);
        counted = !(cmd == CMD_SPARE_A || cmd == CMD_SPARE_B);
    endtask

    initial
    begin
        bit counted;
        int items;

        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_BUS_EIGHT;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.cmd     = CMD_INSTR;
        req_ch.value   = '0;
        req_ch.row     = '0;
        req_ch.column  = '0;
        rsp_ch.ready   = 1'b0;
        idling_on      = 1'b1;
        cycle_count    = 0;
        rsp_stall_left = 0;
        settings_used  = 1;
        spare_sent     = 0;
        board          = new();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset settings (4-bit bus, function set 8, display 0x0C).
        send_command(CMD_INIT, 32'd0, 3'd0, 5'd0);
        send_command(CMD_INSTR, 32'h0000_0000, 3'd0, 5'd0);
        send_command(CMD_INSTR, 32'hFFFF_FFFF, 3'd7, 5'd31);
        send_command(CMD_DATA, 32'h5A5A_5AA5, 3'd0, 5'd0);
        send_command(CMD_DATA, 32'hA5A5_A55A, 3'd0, 5'd0);
        // every row base, both column ends
        send_command(CMD_CURSOR, 32'd0, 3'd1, 5'd1);
        send_command(CMD_CURSOR, 32'd0, 3'd4, 5'd20);
        send_command(CMD_CURSOR, 32'd0, 3'd2, 5'd10);
        send_command(CMD_CURSOR, 32'd0, 3'd3, 5'd5);
        // positions off the panel: error beat, no strobe
        send_command(CMD_CURSOR, 32'd0, 3'd0, 5'd1);
        send_command(CMD_CURSOR, 32'd0, 3'd5, 5'd1);
        send_command(CMD_CURSOR, 32'd0, 3'd7, 5'd31);
        send_command(CMD_CURSOR, 32'd0, 3'd1, 5'd0);
        send_command(CMD_CURSOR, 32'd0, 3'd1, 5'd21);
        send_command(CMD_CHAR, 32'h0000_0041, 3'd3, 5'd7);
        send_command(CMD_CHAR, 32'hFFFF_FFFF, 3'd2, 5'd20);
        send_command(CMD_CHAR, 32'h0000_0042, 3'd4, 5'd31);
        // zero prints one digit; the widest value prints ten
        send_command(CMD_INT, 32'd0, 3'd1, 5'd1);
        send_command(CMD_INT, 32'hFFFF_FFFF, 3'd4, 5'd1);
        send_command(CMD_INT, 32'd1234567890, 3'd2, 5'd3);
        send_command(CMD_INT, 32'd7, 3'd3, 5'd20);
        send_command(CMD_INT, 32'd100, 3'd0, 5'd5);
        // unused codes: no beats at all
        send_command(CMD_SPARE_A, 32'hFFFF_FFFF, 3'd1, 5'd1);
        send_command(CMD_SPARE_B, 32'h0000_0000, 3'd2, 5'd2);
        drain_block();

        // Random phases, each under its own register setting. The first two
        // use the extremes; the last runs with no idling on either side.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       apply_settings(1'b0, 4'h0, 8'h00);
                1:       apply_settings(1'b1, 4'hF, 8'hFF);
                default: apply_settings(1'($urandom_range(0, 1)),
                                        NIB_W'($urandom_range(0, 15)),
                                        BYTE_W'($urandom_range(0, 255)));
            endcase
            if (phase == RANDOM_PHASES - 1)
                idling_on = 1'b0;
            items = 0;
            while (items < PHASE_ITEMS)
            begin
                random_command(counted);
                if (counted)
                    items++;
                // hold the sender off once until the block has fully emptied
                if (phase == 2 && items == PHASE_ITEMS / 2 && counted)
                    drain_block();
            end
            drain_block();
        end

        $display("ran %0d commands (%0d ignored codes) under %0d register settings",
                 board.commands_seen, spare_sent, settings_used);
        $display("checked %0d result beats field by field, %0d errors",
                 board.beats_seen, board.errors);
        if (board.errors == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
